>>> rtl/pswz_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and channel-position table for the pixel swizzle unit.
package pswz_pkg;

    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int NUM_COLOR  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    // Divider pipeline: quotient bits retired per stage.
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = CH_W / DIV_STAGES;
    // Unpack stage + divider stages + pack/output stage.
    localparam int PIPE_DEPTH     = DIV_STAGES + 2;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int CH_A = 3;

    typedef enum logic [1:0] {
        ORD_RGBA = 2'd0,
        ORD_BGRA = 2'd1,
        ORD_ARGB = 2'd2,
        ORD_ABGR = 2'd3
    } t_order;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_ORDER = 3'd0,
        REG_TGT_ORDER = 3'd1,
        REG_SRC_PM    = 3'd2,
        REG_TGT_PM    = 3'd3,
        REG_OPAQUE    = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_REORDER,
        MODE_PASS,
        MODE_ZERO,
        MODE_PREMUL,
        MODE_UNPREMUL
    } t_mode;

    typedef struct packed {
        t_order src_order;
        t_order tgt_order;
        logic   src_pm;
        logic   tgt_pm;
        logic   opaque;
    } t_cfg;

    typedef struct packed {
        t_mode                               mode;
        logic                                last;
        logic [NUM_CH-1:0][CH_W-1:0]         ch;
        logic [NUM_COLOR-1:0][CH_W-1:0]      rem;
        logic [NUM_COLOR-1:0][CH_W-1:0]      quo;
        logic [NUM_COLOR-1:0]                sat;
    } t_work;

    // Byte position of R, G, B, A for each channel order.
    localparam logic [1:0] CHAN_POS [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd1, 2'd0, 2'd3},
        '{2'd1, 2'd2, 2'd3, 2'd0},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    function automatic logic [1:0] chan_pos(t_order ord, logic [1:0] ch);
        return CHAN_POS[ord][ch];
    endfunction

endpackage

>>> rtl/pswz_if.sv
`timescale 1ns / 1ps
// Request channels carrying input and output pixels.
interface pswz_in_if;
    import pswz_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             last_in;

    modport source(output valid, pixel_in, last_in, input ready);
    modport sink(input valid, pixel_in, last_in, output ready);
endinterface

interface pswz_out_if;
    import pswz_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             last_out;

    modport source(output valid, pixel_out, last_out, input ready);
    modport sink(input valid, pixel_out, last_out, output ready);
endinterface

>>> rtl/pswz_unpack.sv
`timescale 1ns / 1ps
// First stage: channel extraction, mode decode, premultiply and divider setup.
module pswz_unpack (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [pswz_pkg::PIX_W-1:0]  i_pixel,
    input  logic                        i_last,
    input  pswz_pkg::t_cfg              i_cfg,
    output pswz_pkg::t_work             o_work
);
    import pswz_pkg::*;

    t_work                     r_work;
    t_work                     n_work;
    logic [NUM_CH-1:0][CH_W-1:0] chv;
    logic [CH_W-1:0]           alpha;
    logic [2*CH_W:0]           prod [NUM_COLOR];

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            chv[c] = i_pixel[CH_W*int'(chan_pos(i_cfg.src_order, 2'(c))) +: CH_W];
        end
        alpha = chv[CH_A];

        n_work.last = i_last;
        if (i_cfg.src_pm == i_cfg.tgt_pm) begin
            n_work.mode = MODE_REORDER;
        end else if (i_cfg.opaque) begin
            n_work.mode = MODE_PASS;
        end else if (alpha == '0) begin
            n_work.mode = MODE_ZERO;
        end else if (i_cfg.tgt_pm) begin
            n_work.mode = MODE_PREMUL;
        end else begin
            n_work.mode = MODE_UNPREMUL;
        end

        n_work.ch = chv;
        for (int c = 0; c < NUM_COLOR; c++) begin
            // c * (a + 1) >> 8
            prod[c] = (2*CH_W+1)'(chv[c]) * ((2*CH_W+1)'(alpha) + (2*CH_W+1)'(1));
            // c >= a means (c << 8) / a is at least 256: saturate
            n_work.sat[c] = (chv[c] >= alpha);
            n_work.rem[c] = chv[c];
            n_work.quo[c] = '0;
            if (n_work.mode == MODE_PREMUL) begin
                n_work.ch[c] = prod[c][2*CH_W-1:CH_W];
            end else if (n_work.mode == MODE_ZERO) begin
                n_work.ch[c] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_work = r_work;

endmodule

>>> rtl/pswz_div_step.sv
`timescale 1ns / 1ps
// One divider stage: retires two quotient bits of (c << 8) / a per colour lane of unpremultiply pixels.
module pswz_div_step (
    input  logic             i_clk,
    input  logic             i_en,
    input  pswz_pkg::t_work  i_work,
    output pswz_pkg::t_work  o_work
);
    import pswz_pkg::*;

    t_work           r_work;
    t_work           n_work;
    logic [CH_W:0]   trial;
    logic [CH_W:0]   divisor;
    logic [CH_W-1:0] rem_v;
    logic [CH_W-1:0] quo_v;

    always_comb begin
        n_work  = i_work;
        divisor = {1'b0, i_work.ch[CH_A]};
        trial   = '0;
        rem_v   = '0;
        quo_v   = '0;
        if (i_work.mode == MODE_UNPREMUL) begin
            for (int c = 0; c < NUM_COLOR; c++) begin
                rem_v = i_work.rem[c];
                quo_v = i_work.quo[c];
                // restoring steps; remainder stays below a unless the lane saturates, dividend low bits are zero
                for (int s = 0; s < BITS_PER_STAGE; s++) begin
                    trial = {rem_v, 1'b0};
                    if (trial >= divisor) begin
                        rem_v = CH_W'(trial - divisor);
                        quo_v = {quo_v[CH_W-2:0], 1'b1};
                    end else begin
                        rem_v = trial[CH_W-1:0];
                        quo_v = {quo_v[CH_W-2:0], 1'b0};
                    end
                end
                n_work.rem[c] = rem_v;
                n_work.quo[c] = quo_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_work = r_work;

endmodule

>>> rtl/pswz_pack.sv
`timescale 1ns / 1ps
// Last stage: final colour select and repacking into the output register.
module pswz_pack (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  pswz_pkg::t_work             i_work,
    input  pswz_pkg::t_cfg              i_cfg,
    output logic [pswz_pkg::PIX_W-1:0]  o_pixel,
    output logic                        o_last
);
    import pswz_pkg::*;

    logic [PIX_W-1:0]            r_pixel;
    logic                        r_last;
    logic [PIX_W-1:0]            n_pixel;
    logic [NUM_CH-1:0][CH_W-1:0] val;
    t_order                      ord;

    always_comb begin
        val = i_work.ch;
        if (i_work.mode == MODE_UNPREMUL) begin
            for (int c = 0; c < NUM_COLOR; c++) begin
                val[c] = i_work.sat[c] ? {CH_W{1'b1}} : i_work.quo[c];
            end
        end
        // opaque pass-through writes the channels back where they came from
        ord     = (i_work.mode == MODE_PASS) ? i_cfg.src_order : i_cfg.tgt_order;
        n_pixel = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            n_pixel[CH_W*int'(chan_pos(ord, 2'(c))) +: CH_W] = val[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
            r_last  <= i_work.last;
        end
    end

    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule

>>> rtl/pixel_swizzle_alpha_premultiply_unit.sv
`timescale 1ns / 1ps
// Pixel channel-order and alpha premultiply converter, top level.
//
// i_pix carries one 32-bit pixel (memory byte k at bits 8k+7:8k) and a last
// flag per request; o_pix returns the converted pixel and the same flag.
// Both use valid/ready; a request moves when both are high.
// Configuration is a write-only port: i_cfg_we, i_cfg_idx, i_cfg_data.
// Registers: 0 source order, 1 target order, 2 source premultiplied,
// 3 target premultiplied, 4 image opaque. Write them only while idle.
//
// The pipeline stages are unpack/premultiply, four divider stages of 2
// quotient bits each for unpremultiply, and the pack/output register.
// Throughput is one pixel per cycle while o_pix.ready is high; the divider
// is fully pipelined. Each stage holds while the one ahead is full and
// stalled, so empty stages still fill while o_pix is held off; i_pix.ready
// drops only when all six stages hold a pixel and o_pix.ready is low.
// Reset clears all stage valid bits and the configuration registers to 0.
module pixel_swizzle_alpha_premultiply_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pswz_in_if.sink                          i_pix,
    pswz_out_if.source                       o_pix,
    input  logic                             i_cfg_we,
    input  logic [pswz_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pswz_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pswz_pkg::*;

    t_cfg                  r_cfg;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;
    logic [PIPE_DEPTH-1:0] take;
    t_work                 w_stage [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SRC_ORDER: r_cfg.src_order <= t_order'(i_cfg_data);
                REG_TGT_ORDER: r_cfg.tgt_order <= t_order'(i_cfg_data);
                REG_SRC_PM:    r_cfg.src_pm    <= i_cfg_data[0];
                REG_TGT_PM:    r_cfg.tgt_pm    <= i_cfg_data[0];
                REG_OPAQUE:    r_cfg.opaque    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        take[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || o_pix.ready;
        for (int k = PIPE_DEPTH-2; k >= 0; k--) begin
            take[k] = !r_vld[k] || take[k+1];
        end
        for (int k = 0; k < PIPE_DEPTH; k++) begin
            if (!take[k]) begin
                n_vld[k] = r_vld[k];
            end else if (k == 0) begin
                n_vld[k] = i_pix.valid;
            end else begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pix.ready = take[0];
    assign o_pix.valid = r_vld[PIPE_DEPTH-1];

    pswz_unpack u_unpack (
        .i_clk   (i_clk),
        .i_en    (take[0]),
        .i_pixel (i_pix.pixel_in),
        .i_last  (i_pix.last_in),
        .i_cfg   (r_cfg),
        .o_work  (w_stage[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        pswz_div_step u_div_step (
            .i_clk  (i_clk),
            .i_en   (take[g+1]),
            .i_work (w_stage[g]),
            .o_work (w_stage[g+1])
        );
    end

    pswz_pack u_pack (
        .i_clk   (i_clk),
        .i_en    (take[PIPE_DEPTH-1]),
        .i_work  (w_stage[DIV_STAGES]),
        .i_cfg   (r_cfg),
        .o_pixel (o_pix.pixel_out),
        .o_last  (o_pix.last_out)
    );

endmodule

>>> rtl/pswz_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the pixel swizzle unit, bound to the top level.
module pswz_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [pswz_pkg::PIX_W-1:0]  i_pixel_out,
    input  logic                        i_last_out
);
    import pswz_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // pixels in flight
    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pixel_out) && $stable(i_last_out))
        else $error("stalled result changed or vanished");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result offered with no pixel in flight");

    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> r_cnt == CNT_W'(PIPE_DEPTH))
        else $error("input held off while the pipeline has room");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

endmodule

bind pixel_swizzle_alpha_premultiply_unit pswz_checker u_pswz_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_pixel_out (o_pix.pixel_out),
    .i_last_out  (o_pix.last_out)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pixel swizzle / alpha premultiply unit.
module testbench;
    import pswz_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_pix_result;

    typedef struct {
        t_cfg             cfg;
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             fixed;
        logic [PIX_W-1:0] want;
    } t_dir_row;

    localparam int NUM_DIR  = 25;
    localparam int NUM_SEG  = 16;
    localparam int SEG_LEN  = 64;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_FIRST_UNUSED = 3'd5;

    // Register sets: src order, tgt order, src pm, tgt pm, opaque.
    localparam t_cfg C_PLAIN        = {ORD_RGBA, ORD_RGBA, 3'b000};
    localparam t_cfg C_TO_BGRA      = {ORD_RGBA, ORD_BGRA, 3'b000};
    localparam t_cfg C_TO_ARGB      = {ORD_RGBA, ORD_ARGB, 3'b000};
    localparam t_cfg C_TO_ABGR      = {ORD_RGBA, ORD_ABGR, 3'b000};
    localparam t_cfg C_ARGB_RGBA    = {ORD_ARGB, ORD_RGBA, 3'b000};
    localparam t_cfg C_BGRA_ABGR    = {ORD_BGRA, ORD_ABGR, 3'b000};
    localparam t_cfg C_ABGR_ARGB    = {ORD_ABGR, ORD_ARGB, 3'b000};
    localparam t_cfg C_PREMUL       = {ORD_RGBA, ORD_RGBA, 3'b010};
    localparam t_cfg C_UNPREMUL     = {ORD_RGBA, ORD_RGBA, 3'b100};
    localparam t_cfg C_UNPM_SWAP    = {ORD_ARGB, ORD_BGRA, 3'b100};
    localparam t_cfg C_OPQ_PREMUL   = {ORD_ARGB, ORD_ABGR, 3'b011};
    localparam t_cfg C_OPQ_UNPM     = {ORD_RGBA, ORD_RGBA, 3'b101};
    localparam t_cfg C_OPQ_SAME     = {ORD_RGBA, ORD_BGRA, 3'b111};
    localparam t_cfg C_PM_BOTH      = {ORD_ABGR, ORD_RGBA, 3'b110};
    localparam t_cfg C_PREMUL_SWAP  = {ORD_ABGR, ORD_BGRA, 3'b010};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pswz_in_if  in_ch();
    pswz_out_if out_ch();

    pixel_swizzle_alpha_premultiply_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (in_ch),
        .o_pix      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_pix_result converted_fifo[$];
    t_cfg        shadow_cfg;
    int          mismatch_cnt = 0;
    int          src_gap_pct;
    int          sink_stall_pct;
    t_dir_row    dir_rows[NUM_DIR];

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Byte lane of channel ch (R, G, B, A) for a channel order.
    function automatic int byte_slot(t_order ord, int ch);
        case (ord)
            ORD_RGBA: return ch;
            ORD_BGRA: return (ch == CH_A) ? 3 : 2 - ch;
            ORD_ARGB: return (ch == CH_A) ? 0 : ch + 1;
            default:  return 3 - ch;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] convert_pixel(t_cfg c, logic [PIX_W-1:0] px);
        logic [CH_W-1:0]  chan [NUM_CH];
        logic [CH_W-1:0]  a;
        logic [PIX_W-1:0] res;
        int               v;
        if (c.src_pm != c.tgt_pm && c.opaque)
            return px;
        for (int ch = 0; ch < NUM_CH; ch++)
            chan[ch] = px[byte_slot(c.src_order, ch)*8 +: 8];
        if (c.src_pm != c.tgt_pm) begin
            a = chan[CH_A];
            for (int ch = 0; ch < NUM_COLOR; ch++) begin
                if (a == 0)
                    v = 0;
                else if (c.tgt_pm)
                    v = (int'(chan[ch]) * (int'(a) + 1)) >> 8;
                else
                    v = (int'(chan[ch]) << 8) / int'(a);
                if (v > 255)
                    v = 255;
                chan[ch] = v[CH_W-1:0];
            end
        end
        res = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
            res[byte_slot(c.tgt_order, ch)*8 +: 8] = chan[ch];
        return res;
    endfunction

    // Mostly well-formed premultiplied content, with zero/full/tiny alpha bias.
    function automatic logic [PIX_W-1:0] gen_pixel(t_order ord);
        logic [PIX_W-1:0] px;
        logic [CH_W-1:0]  a;
        logic [CH_W-1:0]  c;
        int               sel;
        sel = $urandom_range(9, 0);
        if (sel < 2)
            a = '0;
        else if (sel == 2)
            a = 8'hff;
        else if (sel == 3)
            a = CH_W'($urandom_range(3, 1));
        else
            a = CH_W'($urandom_range(255, 0));
        px = '0;
        px[byte_slot(ord, CH_A)*8 +: 8] = a;
        for (int ch = 0; ch < NUM_COLOR; ch++) begin
            if ($urandom_range(9, 0) < 7)
                c = CH_W'($urandom_range(int'(a), 0));
            else
                c = CH_W'($urandom_range(255, 0));
            px[byte_slot(ord, ch)*8 +: 8] = c;
        end
        return px;
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic lst,
                              input logic fixed, input logic [PIX_W-1:0] want);
        t_pix_result r;
        while ($urandom_range(99, 0) < src_gap_pct) begin
            in_ch.valid    <= 1'b0;
            in_ch.pixel_in <= $urandom;
            in_ch.last_in  <= ($urandom_range(1, 0) != 0);
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.pixel_in <= px;
        in_ch.last_in  <= lst;
        r.pixel = fixed ? want : convert_pixel(shadow_cfg, px);
        r.last  = lst;
        do @(posedge i_clk); while (!in_ch.ready);
        converted_fifo.push_back(r);
        @(negedge i_clk);
    endtask

    // Stop sending, let every pending request drain, then let the pipe settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (converted_fifo.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_DEPTH + 2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
    endtask

    // 1-bit registers get a random upper data bit, which must be masked off.
    // A trailing write to an unused index must be ignored.
    task automatic apply_cfg(input t_cfg c);
        logic junk;
        junk = ($urandom_range(1, 0) != 0);
        cfg_write(REG_SRC_ORDER, c.src_order);
        cfg_write(REG_TGT_ORDER, c.tgt_order);
        cfg_write(REG_SRC_PM, {junk, c.src_pm});
        junk = ($urandom_range(1, 0) != 0);
        cfg_write(REG_TGT_PM, {junk, c.tgt_pm});
        junk = ($urandom_range(1, 0) != 0);
        cfg_write(REG_OPAQUE, {junk, c.opaque});
        cfg_write(REG_IDX_FIRST_UNUSED + 3'($urandom_range(2, 0)), 2'($urandom_range(3, 0)));
        i_cfg_we <= 1'b0;
        shadow_cfg = c;
    endtask

    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);

    always @(posedge i_clk) begin : check_out
        t_pix_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (converted_fifo.size() == 0) begin
                $display("%0t: output with nothing pending: expected none, actual %h last %b",
                         $time, out_ch.pixel_out, out_ch.last_out);
                mismatch_cnt++;
            end else begin
                want = converted_fifo.pop_front();
                if (want.pixel !== out_ch.pixel_out) begin
                    $display("%0t: pixel mismatch: expected %h, actual %h",
                             $time, want.pixel, out_ch.pixel_out);
                    mismatch_cnt++;
                end
                if (want.last !== out_ch.last_out) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, out_ch.last_out);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_cfg     seg_cfg;
        t_dir_row row;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.pixel_in = '0;
        in_ch.last_in  = 1'b0;
        shadow_cfg     = C_PLAIN;
        src_gap_pct    = 0;
        sink_stall_pct = 0;

        dir_rows[0]  = '{C_PLAIN,       32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000};
        dir_rows[1]  = '{C_PLAIN,       32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff};
        dir_rows[2]  = '{C_PLAIN,       32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678};
        dir_rows[3]  = '{C_TO_BGRA,     32'h4433_2211, 1'b0, 1'b1, 32'h4411_2233};
        dir_rows[4]  = '{C_TO_ARGB,     32'h4433_2211, 1'b1, 1'b1, 32'h3322_1144};
        dir_rows[5]  = '{C_TO_ABGR,     32'h4433_2211, 1'b0, 1'b1, 32'h1122_3344};
        dir_rows[6]  = '{C_ARGB_RGBA,   32'h3322_1144, 1'b0, 1'b1, 32'h4433_2211};
        dir_rows[7]  = '{C_BGRA_ABGR,   32'ha1b2_c3d4, 1'b1, 1'b0, 32'h0};
        dir_rows[8]  = '{C_ABGR_ARGB,   32'h0f1e_2d3c, 1'b0, 1'b0, 32'h0};
        // premultiply: full alpha is identity, zero alpha clears colors
        dir_rows[9]  = '{C_PREMUL,      32'hff12_3456, 1'b0, 1'b1, 32'hff12_3456};
        dir_rows[10] = '{C_PREMUL,      32'h00ab_cdef, 1'b1, 1'b1, 32'h0000_0000};
        dir_rows[11] = '{C_PREMUL,      32'h80ff_4020, 1'b0, 1'b0, 32'h0};
        dir_rows[12] = '{C_PREMUL,      32'h01ff_ffff, 1'b0, 1'b0, 32'h0};
        // unpremultiply: saturation, zero alpha
        dir_rows[13] = '{C_UNPREMUL,    32'h01ff_ffff, 1'b1, 1'b1, 32'h01ff_ffff};
        dir_rows[14] = '{C_UNPREMUL,    32'h00ff_ffff, 1'b0, 1'b1, 32'h0000_0000};
        dir_rows[15] = '{C_UNPREMUL,    32'hff80_4020, 1'b0, 1'b0, 32'h0};
        dir_rows[16] = '{C_UNPREMUL,    32'h8080_8080, 1'b0, 1'b0, 32'h0};
        dir_rows[17] = '{C_UNPM_SWAP,   32'hc060_4020, 1'b1, 1'b0, 32'h0};
        // opaque: untouched when flags differ, plain reorder when they match; non-opaque rows follow
        dir_rows[18] = '{C_OPQ_PREMUL,  32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678};
        dir_rows[19] = '{C_OPQ_UNPM,    32'h00ff_ffff, 1'b0, 1'b1, 32'h00ff_ffff};
        dir_rows[20] = '{C_OPQ_SAME,    32'h4433_2211, 1'b1, 1'b1, 32'h4411_2233};
        dir_rows[21] = '{C_PM_BOTH,     32'hdead_beef, 1'b0, 1'b0, 32'h0};
        dir_rows[22] = '{C_PREMUL_SWAP, 32'h7f00_ff01, 1'b0, 1'b0, 32'h0};
        dir_rows[23] = '{C_PLAIN,       32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff};
        dir_rows[24] = '{C_UNPREMUL,    32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIR; k++) begin
            row = dir_rows[k];
            if (row.cfg != shadow_cfg) begin
                wait_idle();
                apply_cfg(row.cfg);
            end
            push_pixel(row.pixel, row.last, row.fixed, row.want);
        end

        for (int seg = 0; seg < NUM_SEG; seg++) begin
            case (seg)
                0: seg_cfg = {ORD_ABGR, ORD_RGBA, 3'b010};
                1: seg_cfg = {ORD_RGBA, ORD_ABGR, 3'b100};
                2: seg_cfg = {ORD_ARGB, ORD_BGRA, 3'b101};
                3: seg_cfg = {ORD_BGRA, ORD_ARGB, 3'b111};
                default: begin
                    seg_cfg.src_order = t_order'($urandom_range(3, 0));
                    seg_cfg.tgt_order = t_order'($urandom_range(3, 0));
                    seg_cfg.src_pm    = ($urandom_range(1, 0) != 0);
                    seg_cfg.tgt_pm    = ($urandom_range(9, 0) < 7) ? !seg_cfg.src_pm
                                                                   : seg_cfg.src_pm;
                    seg_cfg.opaque    = ($urandom_range(4, 0) == 0);
                end
            endcase
            wait_idle();
            apply_cfg(seg_cfg);
            case (seg % 4)
                0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_gap_pct = 76; sink_stall_pct = 0;  end
                2: begin src_gap_pct = 0;  sink_stall_pct = 76; end
                default: begin src_gap_pct = 26; sink_stall_pct = 26; end
            endcase
            for (int i = 0; i < SEG_LEN; i++) begin
                push_pixel(gen_pixel(seg_cfg.src_order),
                           (i == SEG_LEN - 1) || ($urandom_range(15, 0) == 0), 1'b0, '0);
                // hold off mid-image until the pipe is empty
                if (seg == 6 && i == SEG_LEN / 2)
                    wait_idle();
            end
        end

        wait_idle();
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
